@@ rtl/hrp_pkg.sv @@
// shared types, codes and constants of the http request header parser
package hrp_pkg;

	// width of byte offsets and counters
	localparam int OFF_W = 16;

	// byte queue between front and back, depth must be a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// parse phases
	localparam logic [3:0] PH_METHOD     = 4'd0;
	localparam logic [3:0] PH_URI_FIRST  = 4'd1;
	localparam logic [3:0] PH_URI        = 4'd2;
	localparam logic [3:0] PH_VERSION    = 4'd3;
	localparam logic [3:0] PH_FIRST_LF   = 4'd4;
	localparam logic [3:0] PH_LINE_START = 4'd5;
	localparam logic [3:0] PH_KEY        = 4'd6;
	localparam logic [3:0] PH_VALUE_SKIP = 4'd7;
	localparam logic [3:0] PH_VALUE      = 4'd8;
	localparam logic [3:0] PH_FIELD_LF   = 4'd9;
	localparam logic [3:0] PH_END_LF     = 4'd10;
	localparam logic [3:0] PH_DONE       = 4'd11;
	localparam logic [3:0] PH_ERROR      = 4'd12;

	// result events
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_URI     = 3'd1;
	localparam logic [2:0] EV_QUERY   = 3'd2;
	localparam logic [2:0] EV_VERSION = 3'd3;
	localparam logic [2:0] EV_FIELD   = 3'd4;
	localparam logic [2:0] EV_DONE    = 3'd5;
	localparam logic [2:0] EV_ERROR   = 3'd6;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// "HTTP/" prefix of the version
	localparam int VER_LEN = 5;
	localparam logic [7:0] VER_PREFIX [VER_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f};

	// classified input byte handed from front to back
	typedef struct packed {
		logic [7:0]         data;
		logic [7:0]         lower;
		logic               first;
		logic               is_space;
		logic               is_cr;
		logic               is_lf;
		logic               is_colon;
		logic               is_qmark;
		logic               is_slash;
		logic               is_zero;
		logic [VER_LEN-1:0] ver_match;
	} hrp_class_t;

	localparam int CLASS_W = $bits(hrp_class_t);

endpackage

@@ rtl/http_request_header_parser_top.sv @@
// top level of the http request header parser
//
// s channel: one raw header byte per transfer, tuser flags the first byte of
//   a new request and restarts the parser in any phase
// m channel: one result per byte while a request is in progress; after the
//   header is done or has failed, bytes are absorbed without result until the
//   next first byte
// cfg channel: max_header_len, which the user must write only while the block is
//   idle (the block itself does not enforce this); always ready
// path: an accepted byte is stored in the queue, and its result is then
//   registered in the output register
// throughput: one byte per cycle while the receiver holds tready high; the
//   back end updates the parse state once per byte
// a four-entry queue between the classifier and the parser absorbs short
//   output stalls; when the receiver holds tready low the output register
//   holds its transfer, the queue fills and s_tready falls once it is full
// reset: arst_n clears the parser state, the queue and the output valid and
//   sets max_header_len to 65535
module http_request_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] stored_byte, [23:8] offset_primary,
	                               // [39:24] offset_value, [55:40] field_total,
	                               // [57:56] error_code, rest zero
	output logic [2:0]  m_tuser,   // [2:0] event_res
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data    // max_header_len
);

	logic [hrp_pkg::OFF_W-1:0] max_len_q;

	hrp_pkg::hrp_class_t push_item;
	hrp_pkg::hrp_class_t pop_item;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;

	// length limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// classify incoming bytes
	hrp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (push),
		.q_item   (push_item)
	);

	// decouple classifier from parser
	hrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// parse and drive results
	hrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (pop),
		.max_len  (max_len_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/hrp_front.sv @@
// front end: accepts input bytes and classifies them
module hrp_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] first_byte
	input  logic              q_full,
	output logic              q_push,
	output hrp_pkg::hrp_class_t q_item
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.data      = s_tdata;
		q_item.first     = s_tuser;
		q_item.is_space  = (s_tdata == hrp_pkg::CH_SPACE);
		q_item.is_cr     = (s_tdata == hrp_pkg::CH_CR);
		q_item.is_lf     = (s_tdata == hrp_pkg::CH_LF);
		q_item.is_colon  = (s_tdata == hrp_pkg::CH_COLON);
		q_item.is_qmark  = (s_tdata == hrp_pkg::CH_QMARK);
		q_item.is_slash  = (s_tdata == hrp_pkg::CH_SLASH);
		q_item.is_zero   = (s_tdata == 8'h00);
		if (s_tdata >= hrp_pkg::CH_UP_A && s_tdata <= hrp_pkg::CH_UP_Z) begin
			q_item.lower = s_tdata + hrp_pkg::CASE_GAP;
		end else begin
			q_item.lower = s_tdata;
		end
		for (int i = 0; i < hrp_pkg::VER_LEN; i++) begin
			q_item.ver_match[i] = (s_tdata == hrp_pkg::VER_PREFIX[i]);
		end
	end

endmodule

@@ rtl/hrp_queue.sv @@
// short queue of classified bytes between front and back
module hrp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hrp_pkg::hrp_class_t push_item,
	input  logic                pop,
	output hrp_pkg::hrp_class_t pop_item,
	output logic                full,
	output logic                empty
);

	hrp_pkg::hrp_class_t        slots_q [hrp_pkg::QDEPTH];
	logic [hrp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hrp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hrp_pkg::QCNT_W-1:0] count_q;

	assign full     = (count_q == hrp_pkg::QCNT_W'(hrp_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/hrp_back.sv @@
// back end: parse state machine and output register
module hrp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  hrp_pkg::hrp_class_t          q_item,
	output logic                         q_pop,
	input  logic [hrp_pkg::OFF_W-1:0]    max_len,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,
	output logic [2:0]                   m_tuser
);

	localparam int W = hrp_pkg::OFF_W;

	logic [3:0]   phase_q;
	logic [W-1:0] pos_q;
	logic [2:0]   vidx_q;
	logic [W-1:0] key_q;
	logic [W-1:0] val_q;
	logic [W-1:0] fcnt_q;
	logic         query_q;

	// state after an optional restart
	logic [3:0]   phase_e;
	logic [W-1:0] pos_e;
	logic [2:0]   vidx_e;
	logic [W-1:0] key_e;
	logic [W-1:0] val_e;
	logic [W-1:0] fcnt_e;
	logic         query_e;

	logic [3:0]   phase_n;
	logic [W-1:0] pos_n;
	logic [2:0]   vidx_n;
	logic [W-1:0] key_n;
	logic [W-1:0] val_n;
	logic [W-1:0] fcnt_n;
	logic         query_n;

	logic         has_res;
	logic [7:0]   stored;
	logic [2:0]   ev;
	logic [W-1:0] p1;
	logic [W-1:0] p2;
	logic [1:0]   code;
	logic         ver_hit;

	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic [2:0]   out_ev_q;
	logic [W-1:0] out_p1_q;
	logic [W-1:0] out_p2_q;
	logic [W-1:0] out_fcnt_q;
	logic [1:0]   out_code_q;

	assign q_pop = !q_empty && (!out_valid_q || m_tready);

	always_comb begin
		if (q_item.first) begin
			phase_e = hrp_pkg::PH_METHOD;
			pos_e   = '0;
			vidx_e  = '0;
			key_e   = '0;
			val_e   = '0;
			fcnt_e  = '0;
			query_e = 1'b0;
		end else begin
			phase_e = phase_q;
			pos_e   = pos_q;
			vidx_e  = vidx_q;
			key_e   = key_q;
			val_e   = val_q;
			fcnt_e  = fcnt_q;
			query_e = query_q;
		end

		case (vidx_e)
			3'd0:    ver_hit = q_item.ver_match[0];
			3'd1:    ver_hit = q_item.ver_match[1];
			3'd2:    ver_hit = q_item.ver_match[2];
			3'd3:    ver_hit = q_item.ver_match[3];
			3'd4:    ver_hit = q_item.ver_match[4];
			default: ver_hit = 1'b0;
		endcase

		phase_n = phase_e;
		vidx_n  = vidx_e;
		key_n   = key_e;
		val_n   = val_e;
		fcnt_n  = fcnt_e;
		query_n = query_e;
		pos_n   = pos_e;
		stored  = q_item.data;
		ev      = hrp_pkg::EV_NONE;
		p1      = '0;
		p2      = '0;
		code    = hrp_pkg::ERR_NONE;
		has_res = !(phase_e == hrp_pkg::PH_DONE || phase_e == hrp_pkg::PH_ERROR);

		if (pos_e >= max_len) begin
			code = hrp_pkg::ERR_TOO_LONG;
		end else if (q_item.is_zero) begin
			code = hrp_pkg::ERR_MALFORMED;
		end else begin
			case (phase_e)
				hrp_pkg::PH_METHOD: begin
					if (q_item.is_space) begin
						if (pos_e == '0) begin
							code = hrp_pkg::ERR_MALFORMED;
						end else begin
							stored  = 8'h00;
							phase_n = hrp_pkg::PH_URI_FIRST;
						end
					end else if (q_item.is_cr) begin
						code = hrp_pkg::ERR_MALFORMED;
					end
				end
				hrp_pkg::PH_URI_FIRST: begin
					if (!q_item.is_slash) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else begin
						ev      = hrp_pkg::EV_URI;
						p1      = pos_e;
						phase_n = hrp_pkg::PH_URI;
					end
				end
				hrp_pkg::PH_URI: begin
					if (q_item.is_space) begin
						stored  = 8'h00;
						ev      = hrp_pkg::EV_VERSION;
						p1      = pos_e + 1'b1;
						vidx_n  = '0;
						phase_n = hrp_pkg::PH_VERSION;
					end else if (q_item.is_cr) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else if (q_item.is_qmark && !query_e) begin
						stored  = 8'h00;
						ev      = hrp_pkg::EV_QUERY;
						p1      = pos_e + 1'b1;
						query_n = 1'b1;
					end
				end
				hrp_pkg::PH_VERSION: begin
					if (vidx_e < 3'(hrp_pkg::VER_LEN)) begin
						if (!ver_hit) begin
							code = hrp_pkg::ERR_MALFORMED;
						end else begin
							vidx_n = vidx_e + 1'b1;
						end
					end else if (q_item.is_cr) begin
						stored  = 8'h00;
						phase_n = hrp_pkg::PH_FIRST_LF;
					end
				end
				hrp_pkg::PH_FIRST_LF: begin
					if (!q_item.is_lf) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else begin
						phase_n = hrp_pkg::PH_LINE_START;
					end
				end
				hrp_pkg::PH_LINE_START: begin
					if (q_item.is_cr) begin
						phase_n = hrp_pkg::PH_END_LF;
					end else if (q_item.is_colon) begin
						stored  = 8'h00;
						key_n   = pos_e;
						phase_n = hrp_pkg::PH_VALUE_SKIP;
					end else begin
						stored  = q_item.lower;
						key_n   = pos_e;
						phase_n = hrp_pkg::PH_KEY;
					end
				end
				hrp_pkg::PH_KEY: begin
					if (q_item.is_colon) begin
						stored  = 8'h00;
						phase_n = hrp_pkg::PH_VALUE_SKIP;
					end else if (q_item.is_cr) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else begin
						stored = q_item.lower;
					end
				end
				hrp_pkg::PH_VALUE_SKIP: begin
					if (!q_item.is_space) begin
						val_n = pos_e;
						if (q_item.is_cr) begin
							stored  = 8'h00;
							phase_n = hrp_pkg::PH_FIELD_LF;
						end else begin
							phase_n = hrp_pkg::PH_VALUE;
						end
					end
				end
				hrp_pkg::PH_VALUE: begin
					if (q_item.is_cr) begin
						stored  = 8'h00;
						phase_n = hrp_pkg::PH_FIELD_LF;
					end
				end
				hrp_pkg::PH_FIELD_LF: begin
					if (!q_item.is_lf) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else begin
						fcnt_n  = fcnt_e + 1'b1;
						ev      = hrp_pkg::EV_FIELD;
						p1      = key_e;
						p2      = val_e;
						phase_n = hrp_pkg::PH_LINE_START;
					end
				end
				hrp_pkg::PH_END_LF: begin
					if (!q_item.is_lf) begin
						code = hrp_pkg::ERR_MALFORMED;
					end else begin
						ev      = hrp_pkg::EV_DONE;
						p1      = pos_e + 1'b1;
						phase_n = hrp_pkg::PH_DONE;
					end
				end
				default: begin
					code = hrp_pkg::ERR_MALFORMED;
				end
			endcase
		end

		if (code != hrp_pkg::ERR_NONE) begin
			stored  = q_item.data;
			ev      = hrp_pkg::EV_ERROR;
			p1      = pos_e;
			p2      = '0;
			phase_n = hrp_pkg::PH_ERROR;
		end else begin
			pos_n = pos_e + 1'b1;
		end

		// finished request: bytes pass without touching state
		if (!has_res) begin
			phase_n = phase_e;
			pos_n   = pos_e;
			vidx_n  = vidx_e;
			key_n   = key_e;
			val_n   = val_e;
			fcnt_n  = fcnt_e;
			query_n = query_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrp_pkg::PH_METHOD;
			pos_q       <= '0;
			vidx_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			fcnt_q      <= '0;
			query_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= phase_n;
				pos_q       <= pos_n;
				vidx_q      <= vidx_n;
				key_q       <= key_n;
				val_q       <= val_n;
				fcnt_q      <= fcnt_n;
				query_q     <= query_n;
				out_valid_q <= has_res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_res) begin
			out_byte_q <= stored;
			out_ev_q   <= ev;
			out_p1_q   <= p1;
			out_p2_q   <= p2;
			out_fcnt_q <= fcnt_n;
			out_code_q <= code;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ev_q;
	assign m_tdata  = {6'b0, out_code_q, out_fcnt_q, out_p2_q, out_p1_q, out_byte_q};

endmodule

@@ rtl/hrp_checker.sv @@
// port-level checks of the http request header parser
module hrp_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// error code only with the error event
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == hrp_pkg::EV_ERROR) == (m_tdata[57:56] != hrp_pkg::ERR_NONE)))
		else $error("error code and event disagree");

	// plain bytes carry no offsets
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == hrp_pkg::EV_NONE |-> m_tdata[39:8] == '0)
		else $error("offsets on a plain byte");

	// field and header completion land on a line feed
	a_lf_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == hrp_pkg::EV_FIELD || m_tuser == hrp_pkg::EV_DONE)
		|-> m_tdata[7:0] == hrp_pkg::CH_LF)
		else $error("line completion not on a line feed");

endmodule

bind http_request_header_parser_top hrp_port_checks u_hrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ verif/hrp_checker.sv @@
// checker for the http request header parser: predicts each result and compares
`timescale 1ns / 100ps

module hrp_checker
	import hrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output logic        results_pending
);

	localparam logic [15:0] LEN_LIMIT_RESET = 16'hffff;

	typedef struct packed {
		logic [7:0]       stored;
		logic [2:0]       ev;
		logic [OFF_W-1:0] prim_ofs;
		logic [OFF_W-1:0] value_ofs;
		logic [15:0]      nfields;
		logic [1:0]       err;
	} parse_result_t;

	// parser image
	logic [3:0]       phase;
	logic [OFF_W-1:0] byte_pos;
	logic [2:0]       ver_idx;
	logic [OFF_W-1:0] key_ofs;
	logic [OFF_W-1:0] val_ofs;
	logic [15:0]      field_cnt;
	logic             query_hit;
	logic [15:0]      len_limit;

	parse_result_t parsed_q[$];
	int            n_bad;

	task automatic restart_parser();
		phase     = PH_METHOD;
		byte_pos  = '0;
		ver_idx   = '0;
		key_ofs   = '0;
		val_ofs   = '0;
		field_cnt = '0;
		query_hit = 1'b0;
	endtask

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
	endfunction

	// one byte through the parser image, queues the result it causes
	task automatic parse_byte(input logic [7:0] b, input logic restart);
		parse_result_t    r;
		logic [1:0]       code;
		logic [OFF_W-1:0] pos;
		if (restart)
			restart_parser();
		if (phase == PH_DONE || phase == PH_ERROR)
			return;
		pos = byte_pos;
		r = '0;
		r.stored = b;
		r.ev = EV_NONE;
		code = ERR_NONE;
		if (pos >= len_limit) begin
			code = ERR_TOO_LONG;
		end else if (b == '0) begin
			code = ERR_MALFORMED;
		end else begin
			case (phase)
				PH_METHOD: begin
					if (b == CH_SPACE) begin
						if (pos == '0) code = ERR_MALFORMED;
						else begin
							r.stored = '0;
							phase = PH_URI_FIRST;
						end
					end else if (b == CH_CR) begin
						code = ERR_MALFORMED;
					end
				end
				PH_URI_FIRST: begin
					if (b != CH_SLASH) code = ERR_MALFORMED;
					else begin
						r.ev = EV_URI;
						r.prim_ofs = pos;
						phase = PH_URI;
					end
				end
				PH_URI: begin
					if (b == CH_SPACE) begin
						r.stored = '0;
						r.ev = EV_VERSION;
						r.prim_ofs = pos + 1'b1;
						ver_idx = '0;
						phase = PH_VERSION;
					end else if (b == CH_CR) begin
						code = ERR_MALFORMED;
					end else if (b == CH_QMARK && !query_hit) begin
						r.stored = '0;
						r.ev = EV_QUERY;
						r.prim_ofs = pos + 1'b1;
						query_hit = 1'b1;
					end
				end
				PH_VERSION: begin
					if (ver_idx < VER_LEN) begin
						if (b != VER_PREFIX[ver_idx]) code = ERR_MALFORMED;
						else ver_idx = ver_idx + 1'b1;
					end else if (b == CH_CR) begin
						r.stored = '0;
						phase = PH_FIRST_LF;
					end
				end
				PH_FIRST_LF: begin
					if (b != CH_LF) code = ERR_MALFORMED;
					else phase = PH_LINE_START;
				end
				PH_LINE_START: begin
					if (b == CH_CR) begin
						phase = PH_END_LF;
					end else if (b == CH_COLON) begin
						r.stored = '0;
						key_ofs = pos;
						phase = PH_VALUE_SKIP;
					end else begin
						r.stored = fold_case(b);
						key_ofs = pos;
						phase = PH_KEY;
					end
				end
				PH_KEY: begin
					if (b == CH_COLON) begin
						r.stored = '0;
						phase = PH_VALUE_SKIP;
					end else if (b == CH_CR) begin
						code = ERR_MALFORMED;
					end else begin
						r.stored = fold_case(b);
					end
				end
				PH_VALUE_SKIP: begin
					if (b != CH_SPACE) begin
						val_ofs = pos;
						if (b == CH_CR) begin
							r.stored = '0;
							phase = PH_FIELD_LF;
						end else begin
							phase = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					if (b == CH_CR) begin
						r.stored = '0;
						phase = PH_FIELD_LF;
					end
				end
				PH_FIELD_LF: begin
					if (b != CH_LF) code = ERR_MALFORMED;
					else begin
						field_cnt = field_cnt + 1'b1;
						r.ev = EV_FIELD;
						r.prim_ofs = key_ofs;
						r.value_ofs = val_ofs;
						phase = PH_LINE_START;
					end
				end
				PH_END_LF: begin
					if (b != CH_LF) code = ERR_MALFORMED;
					else begin
						r.ev = EV_DONE;
						r.prim_ofs = pos + 1'b1;
						phase = PH_DONE;
					end
				end
				default: code = ERR_MALFORMED;
			endcase
		end
		if (code != ERR_NONE) begin
			r.stored = b;
			r.ev = EV_ERROR;
			r.prim_ofs = pos;
			r.value_ofs = '0;
			phase = PH_ERROR;
		end else begin
			byte_pos = pos + 1'b1;
		end
		r.nfields = field_cnt;
		r.err = code;
		parsed_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_bad++;
		end
	endtask

	task automatic check_result();
		parse_result_t w;
		if (parsed_q.size() == 0) begin
			$error("result with nothing expected: stored_byte %0h event_res %0d",
				m_tdata[7:0], m_tuser);
			n_bad++;
			return;
		end
		w = parsed_q.pop_front();
		check_field("stored_byte", 32'(w.stored), 32'(m_tdata[7:0]));
		check_field("event_res", 32'(w.ev), 32'(m_tuser));
		check_field("offset_primary", 32'(w.prim_ofs), 32'(m_tdata[23:8]));
		check_field("offset_value", 32'(w.value_ofs), 32'(m_tdata[39:24]));
		check_field("field_total", 32'(w.nfields), 32'(m_tdata[55:40]));
		check_field("error_code", 32'(w.err), 32'(m_tdata[57:56]));
		check_field("tdata_pad", '0, 32'(m_tdata[63:58]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parser();
			len_limit = LEN_LIMIT_RESET;
			parsed_q.delete();
			n_bad = 0;
			mismatch_count <= 0;
			results_pending <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				len_limit = cfg_data;
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				check_result();
			mismatch_count <= n_bad;
			results_pending <= (parsed_q.size() != 0);
		end
	end

endmodule

@@ verif/tb.sv @@
// testbench top of the http request header parser: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;
	import hrp_pkg::*;

	// input bytes to send, spread over the phases
	localparam int ITEMS = 1650;
	localparam int PHASES = 8;
	// cycles to let in-flight bytes settle after the last expected result
	localparam int SETTLE_CYCLES = 12;
	// hard stop, many times the slowest legal run
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	int   mismatch_count;
	logic results_pending;

	// idling percentages of the current phase
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int cycle_count = 0;
	// input bytes transferred so far
	int bytes_sent = 0;

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	http_request_header_parser_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	hrp_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.results_pending  (results_pending)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// one byte transfer, with random idle cycles in front of it; tvalid stays
	// high afterwards so back-to-back bytes need no extra assignment
	task automatic push_byte(input logic [7:0] b, input logic restart);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_text(input string txt, input logic restart);
		for (int i = 0; i < txt.len(); i++)
			push_byte(txt[i], restart && i == 0);
	endtask

	// wait for every predicted result to be taken, then for bytes that were
	// absorbed without result to leave the pipe
	task automatic wait_drained();
		do @(posedge clk); while (results_pending);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input int len);
		cfg_valid <= 1'b1;
		cfg_data <= len[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] req_bytes[$];
		logic [7:0] ch;
		int         colon_at;
		int         n_chars;
		int         n_lines;
		int         pick;
		int         cut;
		bit         noisy;
		int         limit_set[PHASES];
		int         tx_pct_by_phase[4];
		int         rx_pct_by_phase[4];

		// phase 0 keeps the reset value; the rest hit both extremes and a few
		// small limits so that long headers overflow
		limit_set = '{65535, 4, $urandom_range(8, 48), 65535, $urandom_range(20, 60),
			$urandom_range(4, 65535), $urandom_range(10, 40), 65535};
		// no idling, sender idle, receiver stalling, both a little
		tx_pct_by_phase = '{0, 56, 0, 10};
		rx_pct_by_phase = '{0, 0, 56, 10};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a full request sent without a leading restart flag, with a
		// repeated query mark, a mixed-case key and an empty value
		send_text("A /?? HTTP/\015\012Kz:\015\012\015\012", 1'b0);
		// absorbed after done
		push_byte(8'hff, 1'b0);
		// empty method
		push_byte(CH_SPACE, 1'b1);
		// zero byte
		push_byte('0, 1'b1);
		// cr inside the method, top bit set before it
		push_byte(8'h80, 1'b1);
		push_byte(CH_CR, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				// config only while the block is idle
				s_tvalid <= 1'b0;
				wait_drained();
				write_limit(limit_set[phase]);
			end
			tx_idle_pct = tx_pct_by_phase[phase % 4];
			rx_stall_pct <= rx_pct_by_phase[phase % 4];

			while (bytes_sent < (phase + 1) * ITEMS / PHASES) begin
				// well-formed request with random content
				req_bytes.delete();
				colon_at = -1;
				noisy = 1'b0;
				n_chars = $urandom_range(1, 5);
				repeat (n_chars) req_bytes.push_back(8'($urandom_range(CH_UP_A, CH_UP_Z)));
				req_bytes.push_back(CH_SPACE);
				req_bytes.push_back(CH_SLASH);
				n_chars = $urandom_range(0, 8);
				repeat (n_chars)
					req_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_QMARK
						: 8'($urandom_range(33, 255)));
				req_bytes.push_back(CH_SPACE);
				for (int i = 0; i < VER_LEN; i++)
					req_bytes.push_back(VER_PREFIX[i]);
				n_chars = $urandom_range(0, 3);
				repeat (n_chars) req_bytes.push_back(8'($urandom_range(33, 255)));
				req_bytes.push_back(CH_CR);
				req_bytes.push_back(CH_LF);
				n_lines = $urandom_range(0, 3);
				repeat (n_lines) begin
					// key may be empty, letters in either case
					n_chars = $urandom_range(0, 6);
					repeat (n_chars) begin
						pick = $urandom_range(0, 3);
						ch = 8'($urandom_range(CH_UP_A, CH_UP_Z));
						if (pick == 0) ch = 8'($urandom_range(33, 255));
						else if (pick == 1) ch = ch | CASE_GAP;
						req_bytes.push_back(ch);
					end
					colon_at = req_bytes.size();
					req_bytes.push_back(CH_COLON);
					repeat ($urandom_range(0, 2)) req_bytes.push_back(CH_SPACE);
					repeat ($urandom_range(0, 8))
						req_bytes.push_back(8'($urandom_range(32, 255)));
					req_bytes.push_back(CH_CR);
					req_bytes.push_back(CH_LF);
				end
				req_bytes.push_back(CH_CR);
				req_bytes.push_back(CH_LF);

				// broken variants and noise
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					cut = $urandom_range(0, req_bytes.size() - 1);
					case ($urandom_range(0, 5))
						0: req_bytes[cut] = '0;
						1: req_bytes[cut] = CH_CR;
						2: req_bytes[cut] = CH_LF;
						3: req_bytes[cut] = CH_SPACE;
						4: req_bytes[cut] = CH_COLON;
						default: req_bytes[cut] = 8'($urandom_range(0, 255));
					endcase
				end else if (pick < 20) begin
					// cut short, the next request restarts mid-phase
					cut = $urandom_range(1, req_bytes.size() - 1);
					while (req_bytes.size() > cut) void'(req_bytes.pop_back());
				end else if (pick < 25 && colon_at >= 0) begin
					// header line with no colon
					req_bytes[colon_at] = CH_UP_A;
				end else if (pick < 30) begin
					noisy = 1'b1;
					req_bytes.delete();
					repeat ($urandom_range(1, 6))
						req_bytes.push_back(8'($urandom_range(0, 255)));
				end else if (pick < 40) begin
					// trailing bytes after the blank line are absorbed
					repeat ($urandom_range(1, 3))
						req_bytes.push_back(8'($urandom_range(0, 255)));
				end

				for (int i = 0; i < req_bytes.size(); i++)
					push_byte(req_bytes[i], noisy ? ($urandom_range(0, 3) == 0) : (i == 0));
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hrp_pkg.sv
rtl/hrp_front.sv
rtl/hrp_queue.sv
rtl/hrp_back.sv
rtl/http_request_header_parser_top.sv
rtl/hrp_checker.sv
verif/hrp_checker.sv
verif/tb.sv
